/* hdl/mdq_pkg.sv */
package mdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int NUM_W       = 31;
  localparam int POS_W       = 24;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;

  localparam logic [DATA_W-1:0] NOT_MOVED = '1;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_TICK    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RETIRE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] number;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
  } entry_t;

endpackage

/* hdl/three_axis_move_dispatch_queue.sv */
// Ring queue of three-axis move commands with per-axis dispatch.
//
// Request channel: a request (op plus its payload) is taken at a rising edge
// with start high and busy low. busy stays high until the last result of
// that request has been issued.
// Result channel: each result sits on the result ports for one cycle with
// strobe high; the receiver cannot stall, so results are never held back.
// last marks the final result of a request (one to three results each).
// Config channel: cfg_data (take_cmd_number) is written on cfg_valid with
// cfg_ready high; cfg_ready is always high. Write only while idle.
// Sequence: enqueue, clear, enable, disable, and a tick that finds dispatch
// off or the queue empty go from accept straight to the emit state, which
// registers the result strobe. An active tick walks the three axes one
// per cycle through a single target compare/mask unit, then a retire
// step, then the emit state, which issues its results in turn. Next
// request can be taken in the cycle of the last strobe.
// Reset (rst, synchronous) empties the queue, disables dispatch, and zeroes
// the retired number, the enqueue count and the config register. Queue
// slots are not cleared; only written slots are ever read.
module three_axis_move_dispatch_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     op,
  input  logic signed [31:0]             target_x,
  input  logic signed [31:0]             target_y,
  input  logic signed [31:0]             target_z,
  input  logic [30:0]                    cmd_number,
  input  logic [2:0]                     axis_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data,
  output logic                           strobe,
  output logic [1:0]                     kind,
  output logic [1:0]                     axis,
  output logic [23:0]                    position,
  output logic signed [31:0]             completed_number,
  output logic                           queue_full,
  output logic                           queue_empty,
  output logic                           last
);
  import mdq_pkg::*;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  // Control and queue state
  state_t               state, state_next;
  logic [IDX_W-1:0]     head_index;
  logic [IDX_W-1:0]     tail_index;
  logic [NUM_AXES-1:0]  axis_fired;
  logic [DATA_W-1:0]    retired_number;
  logic [DATA_W-1:0]    enqueue_count;
  logic                 dispatch_on;
  logic                 take_cmd_number;

  // Per-request working registers
  logic [NUM_AXES-1:0]  ready_q;     // latched axis_ready of a tick
  logic [NUM_AXES-1:0]  send;        // axes with a move still to report
  logic [POS_W-1:0]     pos_buf [NUM_AXES];
  logic [AXIS_W-1:0]    axis_cnt;    // axis walked by the shared unit
  logic                 rejected;

  // Command store, read at head with registered data
  entry_t               mem [QUEUE_DEPTH];
  entry_t               rd_data;

  // Combinational helpers
  logic                 is_empty;
  logic                 is_full;
  logic                 accept;
  logic [DATA_W-1:0]    cur_target;
  logic                 cur_fire;
  logic                 cur_moved;
  logic [NUM_AXES-1:0]  emit_pick;
  logic [AXIS_W-1:0]    emit_axis;
  logic                 emit_last;
  logic [DATA_W-1:0]    new_number;

  assign is_empty  = (head_index == tail_index);
  assign is_full   = (next_slot(tail_index) == head_index);
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(op) == OP_TICK && dispatch_on && !is_empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (axis_cnt == AXIS_W'(NUM_AXES - 1)) begin
          state_next = ST_RETIRE;
        end
      end
      ST_RETIRE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath decode: shared target compare/mask and result selection
  always_comb begin
    case (axis_cnt)
      2'd0:    cur_target = rd_data.x;
      2'd1:    cur_target = rd_data.y;
      default: cur_target = rd_data.z;
    endcase
    cur_fire  = ready_q[axis_cnt] && !axis_fired[axis_cnt];
    cur_moved = (cur_target != NOT_MOVED);

    // lowest pending axis goes out first
    emit_pick = send & (~send + NUM_AXES'(1));
    emit_axis = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (emit_pick[a]) begin
        emit_axis = AXIS_W'(a);
      end
    end
    emit_last = ((send & ~emit_pick) == '0);

    new_number = take_cmd_number ? {1'b0, cmd_number} : enqueue_count;
  end

  // Store
  always_ff @(posedge clk) begin
    rd_data <= mem[head_index];
    if (state == ST_IDLE && accept && op_t'(op) == OP_ENQUEUE && !is_full) begin
      mem[tail_index] <= '{number: new_number, z: target_z, y: target_y, x: target_x};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      head_index       <= '0;
      tail_index       <= '0;
      axis_fired       <= '0;
      retired_number   <= '0;
      enqueue_count    <= '0;
      dispatch_on      <= 1'b0;
      take_cmd_number  <= 1'b0;
      send             <= '0;
      axis_cnt         <= '0;
      rejected         <= 1'b0;
      strobe           <= 1'b0;
      last             <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      last   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        take_cmd_number <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          send     <= '0;
          axis_cnt <= '0;
          rejected <= 1'b0;
          if (accept) begin
            unique case (op_t'(op))
              OP_ENQUEUE: begin
                if (is_full) begin
                  rejected <= 1'b1;
                end else begin
                  tail_index <= next_slot(tail_index);
                  if (!take_cmd_number) begin
                    enqueue_count <= enqueue_count + DATA_W'(1);
                  end
                end
              end
              OP_TICK: ;
              OP_CLEAR: begin
                head_index    <= '0;
                tail_index    <= '0;
                axis_fired    <= '0;
                enqueue_count <= '0;
                dispatch_on   <= 1'b0;
              end
              OP_ENABLE:  dispatch_on <= 1'b1;
              OP_DISABLE: dispatch_on <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (cur_fire) begin
            axis_fired[axis_cnt] <= 1'b1;
            send[axis_cnt]       <= cur_moved;
          end
          axis_cnt <= axis_cnt + AXIS_W'(1);
        end
        ST_RETIRE: begin
          if (axis_fired == '1) begin
            retired_number <= rd_data.number;
            head_index     <= next_slot(head_index);
            axis_fired     <= '0;
          end
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          last   <= emit_last;
          send   <= send & ~emit_pick;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ready_q <= accept ? axis_ready : ready_q;
    if (state == ST_SCAN && cur_fire) begin
      pos_buf[axis_cnt] <= cur_target[POS_W-1:0];
    end
    if (state == ST_EMIT) begin
      if (send != '0) begin
        kind     <= KIND_MOVE;
        axis     <= emit_axis;
        position <= pos_buf[emit_axis];
      end else begin
        kind     <= rejected ? KIND_REJECT : KIND_STATUS;
        axis     <= '0;
        position <= '0;
      end
      completed_number <= retired_number;
      queue_full       <= is_full;
      queue_empty      <= is_empty;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result strobe directly after last result");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(queue_full && queue_empty))
    else $error("queue reported full and empty at once");

  a_non_move_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind != KIND_MOVE) |-> (axis == '0 && position == '0))
    else $error("non-move result carries axis or position");
`endif

endmodule
